// ===== hdl/dss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the delimiter stream splitter.
// ----------------------------------------------------------------------------
package dss_pkg;

  // Delimiter register: eight bytes, little-endian.
  localparam int DelimRegBytes = 8;
  localparam int DelimRegW     = 8 * DelimRegBytes;
  localparam int DelimByteIdxW = $clog2(DelimRegBytes);
  localparam int LenW          = 4;

  // Default number of window cells.
  localparam int MaxDelimiterBytesDefault = 8;

  // Offsets are counted up to the lower of the string size and 65536.
  localparam int MaxStringBytes = 65536;
  localparam int OffsetLimitInt = (MaxStringBytes < 65536) ? MaxStringBytes : 65536;
  localparam int PosW           = 17;
  localparam int SumW           = PosW + 1;
  localparam int OutW           = 16;
  localparam logic [PosW-1:0] OffsetLimit = PosW'(OffsetLimitInt);

  // Configuration register indexes.
  localparam int CfgIndexW = 1;
  localparam logic [CfgIndexW-1:0] RegDelimBytes = 1'b0;
  localparam logic [CfgIndexW-1:0] RegDelimLen   = 1'b1;

  localparam logic [DelimRegW-1:0] DelimBytesReset = DelimRegW'(44);
  localparam logic [LenW-1:0]      DelimLenReset   = LenW'(1);

  // One input item: a byte of the string.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  // One result item: a segment or a bare end marker.
  typedef struct packed {
    logic [OutW-1:0] segment_start;
    logic [OutW-1:0] segment_length;
    logic            segment_present;
    logic            end_of_string;
    logic            offset_overflow;
  } out_item_t;

  // Control from the segment tracker to the cell row.
  typedef struct packed {
    logic            shift_en;
    logic            clear;
    logic [LenW-1:0] eff_len;
  } win_ctrl_t;

endpackage

// ===== hdl/dss_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_stream_if
// Valid/ready stream channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface dss_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== hdl/delimiter_stream_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimiter_stream_splitter
// Splits a byte stream on a configured delimiter of 1 to 8 bytes.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and gives a result the cycle after
// the byte that causes it, from an output register; a new byte is taken while
// that register is empty or being emptied. The figure of one byte per cycle is
// set by the row of byte cells, which shift the window and compare every
// delimiter byte in parallel in the cycle a byte is taken, together with one
// offset add and compare in the segment tracker. Reset needs no clearing pass.
module delimiter_stream_splitter
  import dss_pkg::*;
#(
  parameter int MAX_DELIMITER_BYTES = MaxDelimiterBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [DelimRegW-1:0] cfg_wdata_i,
  dss_stream_if.sink           in_i,
  dss_stream_if.source         out_o
);

  logic [DelimRegW-1:0] delim_bytes_q;
  logic [LenW-1:0]      delim_len_q;
  logic [LenW-1:0]      eff_len;

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] cur_q, cur_d;
  logic            ovf_q, ovf_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q, out_item_d;

  logic            accept;
  logic            fin;
  logic            ovf_now;
  logic [PosW-1:0] end_pos;
  logic [PosW-1:0] mstart;
  logic            in_reach;
  logic            win_match;
  logic            hit;
  logic            emit;
  logic            present;
  logic [PosW-1:0] seg_start;
  logic [PosW-1:0] seg_len;
  logic            clamped;
  win_ctrl_t       win_ctrl;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_bytes_q <= DelimBytesReset;
      delim_len_q   <= DelimLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegDelimBytes: delim_bytes_q <= cfg_wdata_i;
        RegDelimLen:   delim_len_q   <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Delimiter length limited to 1 .. MAX_DELIMITER_BYTES.
  always_comb begin
    if (delim_len_q == '0) begin
      eff_len = LenW'(1);
    end else if (delim_len_q > LenW'(MAX_DELIMITER_BYTES)) begin
      eff_len = LenW'(MAX_DELIMITER_BYTES);
    end else begin
      eff_len = delim_len_q;
    end
  end

  // Handshake: take a byte while the output register can move on.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign fin        = in_i.payload.final_byte;

  assign win_ctrl.shift_en = accept;
  assign win_ctrl.clear    = accept && fin;
  assign win_ctrl.eff_len  = eff_len;

  dss_window #(
    .NumCells (MAX_DELIMITER_BYTES)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (win_ctrl),
    .byte_i        (in_i.payload.text_byte),
    .delim_bytes_i (delim_bytes_q),
    .match_o       (win_match)
  );

  // Offsets of this byte. The position saturates at the limit, so the offset
  // of the byte is always the stored position.
  assign ovf_now  = pos_q >= OffsetLimit;
  assign end_pos  = pos_q + PosW'(1);
  assign in_reach = {1'b0, end_pos} >= ({1'b0, cur_q} + SumW'(eff_len));
  assign hit      = in_reach && win_match;
  assign mstart   = end_pos - PosW'(eff_len);

  // Segment decision for this byte.
  always_comb begin
    emit      = 1'b0;
    present   = 1'b0;
    seg_start = '0;
    seg_len   = '0;
    cur_d     = cur_q;
    if (hit) begin
      if (mstart != '0) begin
        emit      = 1'b1;
        present   = 1'b1;
        seg_start = cur_q;
        seg_len   = mstart - cur_q;
      end
      cur_d = end_pos;
    end
    if (fin) begin
      emit = 1'b1;
      if (!hit) begin
        present   = 1'b1;
        seg_start = cur_q;
        seg_len   = (end_pos > cur_q) ? (end_pos - cur_q) : '0;
      end
    end
  end

  assign clamped = seg_start[PosW-1] || seg_len[PosW-1];

  // Per-string state update; the final byte clears it.
  always_comb begin
    pos_d = ovf_now ? pos_q : end_pos;
    ovf_d = ovf_q || ovf_now || (emit && clamped);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cur_q <= '0;
      ovf_q <= 1'b0;
    end else if (accept) begin
      if (fin) begin
        pos_q <= '0;
        cur_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        pos_q <= pos_d;
        cur_q <= cur_d;
        ovf_q <= ovf_d;
      end
    end
  end

  // Result item, saturated to the output width.
  always_comb begin
    out_item_d.segment_start   = seg_start[PosW-1] ? '1 : seg_start[OutW-1:0];
    out_item_d.segment_length  = seg_len[PosW-1]   ? '1 : seg_len[OutW-1:0];
    out_item_d.segment_present = present;
    out_item_d.end_of_string   = fin;
    out_item_d.offset_overflow = ovf_d;
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule

// ===== hdl/dss_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_cell
// One window cell: holds one recent byte and compares the byte it takes in.
// ----------------------------------------------------------------------------
module dss_cell
  import dss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_en_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] delim_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       match_o
);

  logic [7:0] byte_q, byte_d;

  // The compare looks at the byte arriving in this cycle.
  assign match_o = !active_i || (byte_i == delim_i);

  // Clearing at the end of a string wins over the shift.
  always_comb begin
    byte_d = byte_q;
    if (clear_i) begin
      byte_d = 8'd0;
    end else if (shift_en_i) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== hdl/dss_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_window
// Row of byte cells, newest byte in cell 0, with the whole-delimiter match.
// ----------------------------------------------------------------------------
module dss_window
  import dss_pkg::*;
#(
  parameter int NumCells = MaxDelimiterBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  win_ctrl_t            ctrl_i,
  input  logic [7:0]           byte_i,
  input  logic [DelimRegW-1:0] delim_bytes_i,
  output logic                 match_o
);

  logic [7:0]          chain_in [NumCells];
  logic [7:0]          cell_q   [NumCells];
  logic [NumCells-1:0] cell_match;
  logic [7:0]          dbyte    [DelimRegBytes];

  // Split the delimiter register into bytes.
  always_comb begin
    for (int b = 0; b < DelimRegBytes; b++) begin
      dbyte[b] = delim_bytes_i[8*b +: 8];
    end
  end

  for (genvar j = 0; j < NumCells; j++) begin : g_cell
    logic                     active;
    logic [LenW-1:0]          k_full;
    logic [DelimByteIdxW-1:0] k;

    // Cell j compares the byte it takes in with delimiter byte len-1-j.
    assign active = ctrl_i.eff_len > LenW'(j);
    assign k_full = ctrl_i.eff_len - LenW'(j + 1);
    assign k      = k_full[DelimByteIdxW-1:0];

    if (j == 0) begin : g_head
      assign chain_in[j] = byte_i;
    end else begin : g_link
      assign chain_in[j] = cell_q[j-1];
    end

    dss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (ctrl_i.shift_en),
      .clear_i    (ctrl_i.clear),
      .byte_i     (chain_in[j]),
      .delim_i    (dbyte[k]),
      .active_i   (active),
      .byte_o     (cell_q[j]),
      .match_o    (cell_match[j])
    );
  end

  assign match_o = &cell_match;

endmodule
